// File: rtl/msig_pkg.sv
package msig_pkg;

	// table geometry
	localparam int SLOTS = 16;
	localparam int PLEN  = 16;

	// field widths
	localparam int SLOT_W = 4;
	localparam int POS_W  = 4;
	localparam int BYTE_W = 8;
	localparam int SEV_W  = 4;
	localparam int LEN_W  = $clog2(PLEN + 1);
	localparam int IDX_W  = $clog2(PLEN);

	// reset value of the severity threshold
	localparam logic [SEV_W-1:0] THRESHOLD_RESET = SEV_W'(8);

	typedef enum logic [1:0] {
		ACT_WRITE_PATTERN = 2'd0,
		ACT_WRITE_HEADER  = 2'd1,
		ACT_SCAN          = 2'd2
	} action_t;

	// one accepted input item
	typedef struct packed {
		logic [1:0]        action;
		logic [SLOT_W-1:0] sig_slot;
		logic [POS_W-1:0]  byte_slot;
		logic [BYTE_W-1:0] pattern_value;
		logic              care;
		logic [4:0]        sig_length;
		logic [SEV_W-1:0]  severity;
		logic [BYTE_W-1:0] scan_byte;
		logic              last_byte;
	} item_t;

	// table write command
	typedef struct packed {
		logic              pat_en;
		logic              hdr_en;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] value;
		logic              care;
		logic [4:0]        len;
		logic [SEV_W-1:0]  sev;
	} tbl_wr_t;

	// scan command
	typedef struct packed {
		logic              en;
		logic [BYTE_W-1:0] data;
		logic              last;
	} scan_cmd_t;

endpackage

// File: rtl/msig_table.sv
module msig_table import msig_pkg::*; (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tbl_wr_t                              wr,
	output logic [SLOTS-1:0][PLEN-1:0][BYTE_W-1:0] pattern,
	output logic [SLOTS-1:0][PLEN-1:0]           care,
	output logic [SLOTS-1:0][LEN_W-1:0]          length,
	output logic [SLOTS-1:0][SEV_W-1:0]          sev
);

	logic [SLOTS-1:0][PLEN-1:0][BYTE_W-1:0] pattern_q;
	logic [SLOTS-1:0][PLEN-1:0]             care_q;
	logic [SLOTS-1:0][LEN_W-1:0]            length_q;
	logic [SLOTS-1:0][SEV_W-1:0]            sev_q;
	logic [LEN_W-1:0]                       len_sat;

	// saturate overlong header lengths
	always_comb begin
		if (5'(wr.len) > 5'(PLEN)) begin
			len_sat = LEN_W'(PLEN);
		end else begin
			len_sat = LEN_W'(wr.len);
		end
	end

	// pattern and care bits, undefined until written
	always_ff @(posedge clk) begin
		if (wr.pat_en) begin
			pattern_q[wr.slot][wr.pos] <= wr.value;
			care_q[wr.slot][wr.pos]    <= wr.care;
		end
	end

	// slot headers, all slots disabled after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			sev_q    <= '0;
		end else if (wr.hdr_en) begin
			length_q[wr.slot] <= len_sat;
			sev_q[wr.slot]    <= wr.sev;
		end
	end

	assign pattern = pattern_q;
	assign care    = care_q;
	assign length  = length_q;
	assign sev     = sev_q;

endmodule

// File: rtl/msig_match.sv
module msig_match import msig_pkg::*; (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scan_cmd_t                            scan,
	input  logic [SLOTS-1:0][PLEN-1:0][BYTE_W-1:0] pattern,
	input  logic [SLOTS-1:0][PLEN-1:0]           care,
	input  logic [SLOTS-1:0][LEN_W-1:0]          length,
	output logic [SLOTS-1:0]                     map_next
);

	logic [PLEN-1:0][BYTE_W-1:0] window_q;
	logic [PLEN-1:0][BYTE_W-1:0] win_next;
	logic [LEN_W-1:0]            fill_q;
	logic [LEN_W-1:0]            fill_next;
	logic [SLOTS-1:0]            matched_q;
	logic [SLOTS-1:0]            hits;

	// window after this byte, newest at position zero
	always_comb begin
		win_next[0] = scan.data;
		for (int k = 1; k < PLEN; k++) begin
			win_next[k] = window_q[k-1];
		end
		if (fill_q == LEN_W'(PLEN)) begin
			fill_next = fill_q;
		end else begin
			fill_next = fill_q + LEN_W'(1);
		end
	end

	// every slot compares against the window in parallel
	always_comb begin
		logic             ok;
		logic [LEN_W-1:0] idx;
		hits = '0;
		for (int s = 0; s < SLOTS; s++) begin
			ok = 1'b1;
			for (int j = 0; j < PLEN; j++) begin
				idx = length[s] - LEN_W'(j) - LEN_W'(1);
				if (LEN_W'(j) < length[s] && care[s][j] &&
				    pattern[s][j] != win_next[idx[IDX_W-1:0]]) begin
					ok = 1'b0;
				end
			end
			hits[s] = ok && length[s] != '0 && fill_next >= length[s];
		end
	end

	assign map_next = matched_q | hits;

	// per-buffer state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			fill_q    <= '0;
			matched_q <= '0;
		end else if (scan.en) begin
			if (scan.last) begin
				window_q  <= '0;
				fill_q    <= '0;
				matched_q <= '0;
			end else begin
				window_q  <= win_next;
				fill_q    <= fill_next;
				matched_q <= map_next;
			end
		end
	end

endmodule

// File: rtl/masked_multi_signature_scanner.sv
// a result is registered: the last buffer byte passes the input register, then the result register
// throughput: one item per cycle while item_stall is low; all signature slots compare in the same cycle
// a held result stalls the input only when the next item also ends a buffer
// reset clears headers, window, fill count, match bits and sets threshold to 8;
// pattern and care bytes are not cleared and must be written before use
module masked_multi_signature_scanner import msig_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [SEV_W-1:0]  cfg_wr_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        action,
	input  logic [SLOT_W-1:0] sig_slot,
	input  logic [POS_W-1:0]  byte_slot,
	input  logic [BYTE_W-1:0] pattern_value,
	input  logic              care,
	input  logic [4:0]        sig_length,
	input  logic [SEV_W-1:0]  severity,
	input  logic [BYTE_W-1:0] scan_byte,
	input  logic              last_byte,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [SLOTS-1:0]  match_map,
	output logic              any_match,
	output logic              critical
);

	logic                                 valid_s1;
	item_t                                item_s1;
	logic                                 produces;
	logic                                 advance;
	tbl_wr_t                              wr;
	scan_cmd_t                            scan;
	logic [SEV_W-1:0]                     threshold_q;
	logic [SLOTS-1:0][PLEN-1:0][BYTE_W-1:0] pattern;
	logic [SLOTS-1:0][PLEN-1:0]           care_bits;
	logic [SLOTS-1:0][LEN_W-1:0]          length;
	logic [SLOTS-1:0][SEV_W-1:0]          sev;
	logic [SLOTS-1:0]                     map_next;
	logic                                 crit_next;
	logic                                 out_valid_q;
	logic [SLOTS-1:0]                     map_q;
	logic                                 any_q;
	logic                                 crit_q;

	// severity threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= '{action: action, sig_slot: sig_slot, byte_slot: byte_slot,
			             pattern_value: pattern_value, care: care,
			             sig_length: sig_length, severity: severity,
			             scan_byte: scan_byte, last_byte: last_byte};
		end
	end

	// the held item moves on unless its result has nowhere to go
	assign produces   = item_s1.action == ACT_SCAN && item_s1.last_byte;
	assign advance    = valid_s1 && (!produces || !out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// decode the held item into table and scan commands
	always_comb begin
		wr          = '0;
		wr.slot     = item_s1.sig_slot;
		wr.pos      = item_s1.byte_slot;
		wr.value    = item_s1.pattern_value;
		wr.care     = item_s1.care;
		wr.len      = item_s1.sig_length;
		wr.sev      = item_s1.severity;
		scan.en     = 1'b0;
		scan.data   = item_s1.scan_byte;
		scan.last   = item_s1.last_byte;
		unique case (item_s1.action)
			ACT_WRITE_PATTERN: wr.pat_en = advance;
			ACT_WRITE_HEADER:  wr.hdr_en = advance;
			ACT_SCAN:          scan.en   = advance;
			default:           ;
		endcase
	end

	msig_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.pattern (pattern),
		.care    (care_bits),
		.length  (length),
		.sev     (sev)
	);

	msig_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan     (scan),
		.pattern  (pattern),
		.care     (care_bits),
		.length   (length),
		.map_next (map_next)
	);

	// any matched slot at or above the threshold
	always_comb begin
		crit_next = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			if (map_next[s] && sev[s] >= threshold_q) begin
				crit_next = 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			map_q  <= map_next;
			any_q  <= |map_next;
			crit_q <= crit_next;
		end
	end

	assign result_valid = out_valid_q;
	assign match_map    = map_q;
	assign any_match    = any_q;
	assign critical     = crit_q;

endmodule

// File: rtl/msig_checker.sv
module msig_checker import msig_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input logic [SLOTS-1:0] match_map,
	input logic             any_match,
	input logic             critical
);

	// a stalled result stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// the summary flag agrees with the bitmap
	a_any_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> any_match == (match_map != '0))
		else $error("any_match disagrees with match_map");

	// a critical report needs a match
	a_crit_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && critical |-> any_match)
		else $error("critical without any match");

	// input is only held back by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with no result waiting");

endmodule

bind masked_multi_signature_scanner msig_checker u_msig_checker (.*);

// File: tb/sv/tb_masked_multi_signature_scanner.sv
module tb_masked_multi_signature_scanner;
	import msig_pkg::*;

	// action code the block must ignore
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int PHASES          = 6;
	localparam int PRESSURE_PHASE  = 5;
	localparam int ITEMS_PER_PHASE = 68;
	localparam int HOLD_CYCLES     = 100;
	localparam int SETTLE_CYCLES   = 4;
	localparam int END_CYCLES      = 10;
	localparam int QUIET_LIMIT     = 1000;

	typedef struct packed {
		logic [SLOTS-1:0] map;
		logic             any;
		logic             crit;
	} scan_report_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_wr_en     = 1'b0;
	logic [SEV_W-1:0]  cfg_wr_data   = '0;
	logic              item_valid    = 1'b0;
	logic              item_stall;
	logic [1:0]        action        = '0;
	logic [SLOT_W-1:0] sig_slot      = '0;
	logic [POS_W-1:0]  byte_slot     = '0;
	logic [BYTE_W-1:0] pattern_value = '0;
	logic              care          = 1'b0;
	logic [4:0]        sig_length    = '0;
	logic [SEV_W-1:0]  severity      = '0;
	logic [BYTE_W-1:0] scan_byte     = '0;
	logic              last_byte     = 1'b0;
	logic              result_valid;
	logic              result_stall  = 1'b0;
	logic [SLOTS-1:0]  match_map;
	logic              any_match;
	logic              critical;

	masked_multi_signature_scanner dut (.*);

	always #5 clk = ~clk;

	// scanner state as tracked on accepted transfers
	logic [BYTE_W-1:0] tbl_bytes [SLOTS*PLEN] = '{default: '0};
	logic              tbl_cares [SLOTS*PLEN] = '{default: '0};
	int                tbl_lens  [SLOTS]      = '{default: 0};
	logic [SEV_W-1:0]  tbl_sevs  [SLOTS]      = '{default: '0};
	logic [BYTE_W-1:0] win_bytes [PLEN]       = '{default: '0};
	int                win_fill               = 0;
	logic [SLOTS-1:0]  sticky_hits            = '0;
	logic [SEV_W-1:0]  crit_level             = THRESHOLD_RESET;
	scan_report_t      owed_reports [$];

	// table contents as seen by the stimulus generator, ahead of the block
	logic [BYTE_W-1:0] gen_bytes   [SLOTS*PLEN] = '{default: '0};
	logic              gen_cares   [SLOTS*PLEN] = '{default: '0};
	bit                gen_written [SLOTS*PLEN] = '{default: 1'b0};
	int                gen_lens    [SLOTS]      = '{default: 0};

	item_t        queued_cmds [$];
	int           items_queued   = 0;
	int           items_made     = 0;
	int           items_accepted = 0;
	int           fail_count     = 0;
	int           phase_idx      = 0;
	int           send_idle_pct  = 16;
	int           recv_idle_pct  = 70;
	int           hold_left      = 0;
	bit           hold_done      = 1'b0;
	int           quiet_cycles   = 0;
	bit           item_taken     = 1'b0;
	bit           got_report     = 1'b0;
	item_t        next_cmd;
	item_t        seen_cmd;
	scan_report_t want;

	// apply one accepted command to the tracked tables and window
	task automatic advance_scanner(input item_t cmd);
		int at;
		int span;
		bit hit;
		scan_report_t rep;
		case (cmd.action)
			ACT_WRITE_PATTERN: begin
				at = cmd.sig_slot * PLEN + cmd.byte_slot;
				tbl_bytes[at] = cmd.pattern_value;
				tbl_cares[at] = cmd.care;
			end
			ACT_WRITE_HEADER: begin
				tbl_lens[cmd.sig_slot] = (cmd.sig_length > PLEN) ? PLEN : cmd.sig_length;
				tbl_sevs[cmd.sig_slot] = cmd.severity;
			end
			ACT_SCAN: begin
				for (int i = PLEN - 1; i > 0; i--)
					win_bytes[i] = win_bytes[i - 1];
				win_bytes[0] = cmd.scan_byte;
				if (win_fill < PLEN)
					win_fill++;
				// oldest pattern byte lines up with the oldest byte of the span
				for (int s = 0; s < SLOTS; s++) begin
					span = tbl_lens[s];
					hit = (span != 0) && (win_fill >= span);
					for (int j = 0; j < span; j++)
						if (tbl_cares[s * PLEN + j] &&
								tbl_bytes[s * PLEN + j] != win_bytes[span - 1 - j])
							hit = 1'b0;
					if (hit)
						sticky_hits[s] = 1'b1;
				end
				if (cmd.last_byte) begin
					rep.map  = sticky_hits;
					rep.any  = |sticky_hits;
					rep.crit = 1'b0;
					for (int s = 0; s < SLOTS; s++)
						if (sticky_hits[s] && tbl_sevs[s] >= crit_level)
							rep.crit = 1'b1;
					owed_reports = {owed_reports, rep};
					win_bytes   = '{default: '0};
					win_fill    = 0;
					sticky_hits = '0;
				end
			end
			default: ;
		endcase
	endtask

	// fully random command, every field toggled
	function automatic item_t random_cmd();
		logic [63:0] r;
		item_t cmd;
		r = {$urandom, $urandom};
		cmd = r[$bits(item_t)-1:0];
		return cmd;
	endfunction

	task automatic push_cmd(input item_t cmd);
		queued_cmds = {queued_cmds, cmd};
		items_queued++;
		if (cmd.action != ACT_UNUSED)
			items_made++;
	endtask

	task automatic add_pattern(input int slot, input int pos, input logic [BYTE_W-1:0] value,
			input logic must_match);
		item_t cmd;
		cmd = random_cmd();
		cmd.action        = ACT_WRITE_PATTERN;
		cmd.sig_slot      = SLOT_W'(slot);
		cmd.byte_slot     = POS_W'(pos);
		cmd.pattern_value = value;
		cmd.care          = must_match;
		gen_bytes[slot * PLEN + pos]   = value;
		gen_cares[slot * PLEN + pos]   = must_match;
		gen_written[slot * PLEN + pos] = 1'b1;
		push_cmd(cmd);
	endtask

	task automatic add_header(input int slot, input int length, input int sev);
		item_t cmd;
		cmd = random_cmd();
		cmd.action     = ACT_WRITE_HEADER;
		cmd.sig_slot   = SLOT_W'(slot);
		cmd.sig_length = 5'(length);
		cmd.severity   = SEV_W'(sev);
		gen_lens[slot] = (length > PLEN) ? PLEN : length;
		push_cmd(cmd);
	endtask

	task automatic add_scan(input logic [BYTE_W-1:0] value, input logic ends_buffer);
		item_t cmd;
		cmd = random_cmd();
		cmd.action    = ACT_SCAN;
		cmd.scan_byte = value;
		cmd.last_byte = ends_buffer;
		push_cmd(cmd);
	endtask

	task automatic add_noise();
		item_t cmd;
		cmd = random_cmd();
		cmd.action = ACT_UNUSED;
		push_cmd(cmd);
	endtask

	// write every byte a slot will compare, then enable it
	task automatic load_signature(input int slot);
		int span;
		int field;
		span = ($urandom_range(3) == 0) ? PLEN : $urandom_range(6, 1);
		for (int j = 0; j < span; j++)
			add_pattern(slot, j, 8'($urandom), $urandom_range(3) != 0);
		field = (span == PLEN && $urandom_range(1) != 0) ? $urandom_range(31, PLEN) : span;
		add_header(slot, field, $urandom_range(15));
	endtask

	// one buffer: planted signatures, near misses and filler, with table writes mixed in
	task automatic queue_buffer(input int lo, input int hi);
		logic [BYTE_W-1:0] buf_bytes [$];
		int live [$];
		int target;
		int slot;
		int span;
		int flip;
		logic [BYTE_W-1:0] b;
		target = $urandom_range(hi, lo);
		for (int s = 0; s < SLOTS; s++)
			if (gen_lens[s] != 0)
				live = {live, s};
		while (buf_bytes.size() < target) begin
			if (live.size() != 0 && $urandom_range(99) < 60) begin
				slot = live[$urandom_range(live.size() - 1)];
				span = gen_lens[slot];
				flip = ($urandom_range(99) < 15) ? $urandom_range(span - 1) : -1;
				for (int j = 0; j < span; j++) begin
					b = gen_cares[slot * PLEN + j] ? gen_bytes[slot * PLEN + j] : 8'($urandom);
					if (j == flip)
						b = b ^ 8'($urandom_range(255, 1));
					buf_bytes = {buf_bytes, b};
				end
			end else begin
				repeat ($urandom_range(4, 1))
					buf_bytes = {buf_bytes, 8'($urandom)};
			end
		end
		foreach (buf_bytes[k]) begin
			if ($urandom_range(19) == 0) begin
				add_pattern($urandom_range(SLOTS - 1), $urandom_range(PLEN - 1), 8'($urandom),
					1'($urandom));
			end else if ($urandom_range(39) == 0) begin
				slot = $urandom_range(SLOTS - 1);
				add_header(slot, ($urandom_range(1) != 0) ? gen_lens[slot] : 0,
					$urandom_range(15));
			end
			add_scan(buf_bytes[k], k == buf_bytes.size() - 1);
		end
	endtask

	// wait for every queued transfer and every report, then let the pipeline empty
	task automatic wait_idle(input int extra);
		while (items_accepted != items_queued || owed_reports.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// input side driver
	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			if (arst_n && queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = queued_cmds.pop_front();
				action        <= next_cmd.action;
				sig_slot      <= next_cmd.sig_slot;
				byte_slot     <= next_cmd.byte_slot;
				pattern_value <= next_cmd.pattern_value;
				care          <= next_cmd.care;
				sig_length    <= next_cmd.sig_length;
				severity      <= next_cmd.severity;
				scan_byte     <= next_cmd.scan_byte;
				last_byte     <= next_cmd.last_byte;
				item_valid    <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result side stall, with one long hold-off in the pressure phase
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (phase_idx == PRESSURE_PHASE && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: check reports, track accepted commands, watchdog
	always @(posedge clk) begin
		got_report = arst_n && result_valid && !result_stall;
		item_taken = arst_n && item_valid && !item_stall;
		if (got_report) begin
			if (owed_reports.size() == 0) begin
				$display("%0t report with none owed: match_map %h any_match %b critical %b",
					$time, match_map, any_match, critical);
				fail_count++;
			end else begin
				want = owed_reports.pop_front();
				if (match_map !== want.map) begin
					$display("%0t match_map: expected %h actual %h", $time, want.map, match_map);
					fail_count++;
				end
				if (any_match !== want.any) begin
					$display("%0t any_match: expected %b actual %b", $time, want.any, any_match);
					fail_count++;
				end
				if (critical !== want.crit) begin
					$display("%0t critical: expected %b actual %b", $time, want.crit, critical);
					fail_count++;
				end
			end
		end
		if (item_taken) begin
			seen_cmd.action        = action;
			seen_cmd.sig_slot      = sig_slot;
			seen_cmd.byte_slot     = byte_slot;
			seen_cmd.pattern_value = pattern_value;
			seen_cmd.care          = care;
			seen_cmd.sig_length    = sig_length;
			seen_cmd.severity      = severity;
			seen_cmd.scan_byte     = scan_byte;
			seen_cmd.last_byte     = last_byte;
			advance_scanner(seen_cmd);
			items_accepted++;
		end
		if (item_taken || got_report)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL masked_multi_signature_scanner");
			$finish;
		end
	end

	// stimulus phases
	initial begin
		int goal;
		int pick;
		int slot;
		int field;
		int span;
		bit fits;
		logic [SEV_W-1:0] level;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < PHASES; phase++) begin
			phase_idx = phase;
			send_idle_pct = (phase / 2 == 0) ? 16 : (phase / 2 == 1) ? 70 : 0;
			recv_idle_pct = (phase / 2 == 0) ? 70 : (phase / 2 == 1) ? 16 : 0;
			if (phase == 0) begin
				// slot 15 left disabled, slot 0 with a cared and a don't-care byte
				add_header(15, 0, 15);
				add_pattern(0, 0, 8'h00, 1'b1);
				add_pattern(0, 1, 8'hFF, 1'b0);
				add_header(0, 2, 15);
				add_noise();
				// two-byte buffer hits slot 0
				add_scan(8'h00, 1'b0);
				add_scan(8'hAB, 1'b1);
				// one-byte buffer is too short for slot 0
				add_scan(8'h00, 1'b1);
				// severity lowered part way through a buffer
				add_scan(8'h00, 1'b0);
				add_header(0, 2, 0);
				add_scan(8'h11, 1'b1);
				// slot disabled part way through a buffer
				add_scan(8'h00, 1'b0);
				add_header(0, 0, 9);
				add_scan(8'h00, 1'b1);
				// lowest and highest slot together, slot 0 severity at the threshold
				add_pattern(15, 0, 8'hFF, 1'b1);
				add_header(15, 1, 7);
				add_header(0, 1, 8);
				add_scan(8'hFF, 1'b0);
				add_scan(8'h00, 1'b1);
			end else begin
				wait_idle(SETTLE_CYCLES);
				level = (phase == 1) ? '0 : (phase == 2) ? '1 :
					(phase == PRESSURE_PHASE) ? THRESHOLD_RESET : SEV_W'($urandom_range(14, 1));
				cfg_wr_data <= level;
				cfg_wr_en   <= 1'b1;
				@(negedge clk);
				cfg_wr_en   <= 1'b0;
				crit_level = level;
			end
			// short buffers back to back so a held result backs up the input
			if (phase == PRESSURE_PHASE)
				repeat (8) queue_buffer(1, 1);
			goal = items_made + ITEMS_PER_PHASE;
			while (items_made < goal) begin
				pick = $urandom_range(99);
				if (pick < 14) begin
					load_signature($urandom_range(SLOTS - 1));
				end else if (pick < 22) begin
					// header rewrite, only where every compared byte is written
					slot = $urandom_range(SLOTS - 1);
					field = $urandom_range(31);
					span = (field > PLEN) ? PLEN : field;
					fits = 1'b1;
					for (int j = 0; j < span; j++)
						if (!gen_written[slot * PLEN + j])
							fits = 1'b0;
					if (fits)
						add_header(slot, field, $urandom_range(15));
					else
						load_signature(slot);
				end else if (pick < 26) begin
					add_noise();
				end else if (pick < 32) begin
					queue_buffer(17, 40);
				end else begin
					queue_buffer(1, 12);
				end
			end
		end
		wait_idle(END_CYCLES);
		if (fail_count == 0 && owed_reports.size() == 0)
			$display("PASS masked_multi_signature_scanner");
		else
			$display("FAIL masked_multi_signature_scanner");
		$finish;
	end

endmodule

// File: masked_multi_signature_scanner.f
rtl/msig_pkg.sv
rtl/msig_table.sv
rtl/msig_match.sv
rtl/masked_multi_signature_scanner.sv
rtl/msig_checker.sv
tb/sv/tb_masked_multi_signature_scanner.sv
